### hdl/ghbb_pkg.sv
// ----------------------------------------------------------------------------
// ghbb_pkg
// Shared types and codes for the generational handle byte buffer block.
// ----------------------------------------------------------------------------
package ghbb_pkg;

  // fixed field widths of the transaction ports
  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 24;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 7;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 3'd0,
    ACT_PUSH   = 3'd1,
    ACT_LENGTH = 3'd2,
    ACT_CLOSE  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  // response status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  // one response transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   byte_out;
  } result_t;

endpackage

### hdl/generational_handle_byte_buffers.sv
// ----------------------------------------------------------------------------
// generational_handle_byte_buffers
// Table of fixed-capacity byte buffers reached through generational handles.
// ----------------------------------------------------------------------------
// Each request transaction passes through the sequencer states in order: the
// slot table entry is read, the handle is checked and the entry written back
// (and the byte store access issued), for a byte read the registered byte
// store read is taken, and the result is handed over to the output register.
// One request is in flight at a time, so a new transaction is taken only once
// the last one has been handed over; a result waiting in the output register
// does not hold the next request back until the following result is ready.
// No clearing pass runs after reset: slot entries are only trusted below the
// fresh slot count, so the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module generational_handle_byte_buffers
  import ghbb_pkg::*;
#(
  parameter int SLOT_WIDTH       = 8,
  parameter int GENERATION_WIDTH = 16,
  parameter int BUFFER_BYTES     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [BYTE_W-1:0]   in_byte_in,
  input  logic [INDEX_W-1:0]  in_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [LENGTH_W-1:0] out_length,
  output logic [BYTE_W-1:0]   out_byte_out
);

  logic    res_valid;
  logic    res_take;
  result_t res;
  logic    out_valid_r;
  result_t out_res_r;

  ghbb_ctrl #(
    .SLOT_WIDTH       (SLOT_WIDTH),
    .GENERATION_WIDTH (GENERATION_WIDTH),
    .BUFFER_BYTES     (BUFFER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_handle  (in_handle),
    .in_byte_in (in_byte_in),
    .in_index   (in_index),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // output register takes a result when empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_handle_out = out_res_r.handle_out;
  assign out_length     = out_res_r.length;
  assign out_byte_out   = out_res_r.byte_out;

endmodule

### hdl/ghbb_ram.sv
// ----------------------------------------------------------------------------
// ghbb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ghbb_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/ghbb_ctrl.sv
// ----------------------------------------------------------------------------
// ghbb_ctrl
// Request sequencer: reads the slot table, checks the handle, writes back the
// slot entry and accesses the byte store.
// ----------------------------------------------------------------------------
module ghbb_ctrl
  import ghbb_pkg::*;
#(
  parameter int SLOT_WIDTH       = 8,
  parameter int GENERATION_WIDTH = 16,
  parameter int BUFFER_BYTES     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [BYTE_W-1:0]   in_byte_in,
  input  logic [INDEX_W-1:0]  in_index,
  output logic                res_valid,
  input  logic                res_take,
  output result_t             res
);

  localparam int SW     = SLOT_WIDTH;
  localparam int GW     = GENERATION_WIDTH;
  localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
  localparam int POS_W  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int HGEN_W = HANDLE_W - SW;
  localparam int CMP_W  = (GW > HGEN_W) ? GW : HGEN_W;

  typedef struct packed {
    logic [GW-1:0]    gen;
    logic [LEN_W-1:0] len;
    logic             closed;
    logic [SW:0]      link;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_BYTE_RD, S_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [ACTION_W-1:0] act_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [SW:0]         head_r, head_nxt;
  logic [SW:0]         fresh_r, fresh_nxt;
  result_t             res_r, res_nxt;

  // memory ports
  logic                slot_rd_en;
  logic [SW-1:0]       slot_rd_addr;
  logic [ENTRY_W-1:0]  slot_rd_data;
  logic                slot_wr_en;
  logic [SW-1:0]       slot_wr_addr;
  slot_entry_t         wr_ent;
  logic                byte_rd_en;
  logic [SW+POS_W-1:0] byte_rd_addr;
  logic [BYTE_W-1:0]   byte_rd_data;
  logic                byte_wr_en;
  logic [SW+POS_W-1:0] byte_wr_addr;

  slot_entry_t         ent;
  logic [SW-1:0]       hslot;
  logic                issued;
  logic                gen_eq;
  logic                hdl_match;
  logic                live;
  logic                buf_full;
  logic                idx_ok;

  ghbb_ram #(.ADDR_W(SW), .DATA_W(ENTRY_W)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (wr_ent),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  ghbb_ram #(.ADDR_W(SW + POS_W), .DATA_W(BYTE_W)) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_wr_addr),
    .wr_data (byte_r),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_rd_data)
  );

  // handle checks against the slot entry just read
  assign ent       = slot_rd_data;
  assign hslot     = hdl_r[SW-1:0];
  assign issued    = {1'b0, hslot} < fresh_r;
  assign gen_eq    = CMP_W'(hdl_r[HANDLE_W-1:SW]) == CMP_W'(ent.gen);
  assign hdl_match = issued && gen_eq;
  assign live      = hdl_match && !ent.closed;
  assign buf_full  = ent.len == LEN_W'(BUFFER_BYTES);
  assign idx_ok    = (LEN_W + INDEX_W)'(idx_r) < (LEN_W + INDEX_W)'(ent.len);

  assign in_stall  = state_r != S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res       = res_r;

  // next state, table updates and result
  always_comb begin
    logic [SW-1:0] s_new;
    logic [GW-1:0] gen_new;
    state_nxt    = state_r;
    head_nxt     = head_r;
    fresh_nxt    = fresh_r;
    res_nxt      = res_r;
    slot_rd_en   = 1'b0;
    slot_rd_addr = (in_action == ACT_ALLOC) ? head_r[SW-1:0] : in_handle[SW-1:0];
    slot_wr_en   = 1'b0;
    slot_wr_addr = hslot;
    wr_ent       = ent;
    byte_rd_en   = 1'b0;
    byte_rd_addr = {hslot, POS_W'(idx_r)};
    byte_wr_en   = 1'b0;
    byte_wr_addr = {hslot, ent.len[POS_W-1:0]};
    s_new        = fresh_r[SW-1:0];
    gen_new      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          slot_rd_en = 1'b1;
          state_nxt  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        case (act_r)
          ACT_ALLOC: begin
            if (!head_r[SW]) begin
              // reuse most recently closed slot
              s_new    = head_r[SW-1:0];
              gen_new  = ent.gen + 1'b1;
              head_nxt = ent.link;
            end else if (!fresh_r[SW]) begin
              s_new     = fresh_r[SW-1:0];
              gen_new   = '0;
              fresh_nxt = fresh_r + 1'b1;
            end else begin
              res_nxt.status = STAT_FULL;
            end
            if (res_nxt.status == STAT_OK) begin
              slot_wr_en         = 1'b1;
              slot_wr_addr       = s_new;
              wr_ent.gen         = gen_new;
              wr_ent.len         = '0;
              wr_ent.closed      = 1'b0;
              res_nxt.handle_out = HANDLE_W'({gen_new, s_new});
            end
          end
          ACT_PUSH: begin
            if (!live) begin
              res_nxt.status = STAT_BAD;
            end else if (buf_full) begin
              res_nxt.status = STAT_FULL;
              res_nxt.length = LENGTH_W'(ent.len);
            end else begin
              byte_wr_en     = 1'b1;
              slot_wr_en     = 1'b1;
              wr_ent.len     = ent.len + 1'b1;
              res_nxt.length = LENGTH_W'(wr_ent.len);
            end
          end
          ACT_LENGTH: begin
            if (!live) begin
              res_nxt.status = STAT_BAD;
            end else begin
              res_nxt.length = LENGTH_W'(ent.len);
            end
          end
          ACT_CLOSE: begin
            if (!hdl_match) begin
              res_nxt.status = STAT_BAD;
            end else if (!ent.closed) begin
              // push slot onto the free list
              slot_wr_en    = 1'b1;
              wr_ent.closed = 1'b1;
              wr_ent.len    = '0;
              wr_ent.link   = head_r;
              head_nxt      = {1'b0, hslot};
            end
          end
          ACT_READ: begin
            if (!live || !idx_ok) begin
              res_nxt.status = STAT_BAD;
            end else begin
              byte_rd_en = 1'b1;
              state_nxt  = S_BYTE_RD;
            end
          end
          default: begin
            res_nxt.status = STAT_BAD;
          end
        endcase
      end
      S_BYTE_RD: begin
        res_nxt.byte_out = byte_rd_data;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, table pointers and captured transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= {1'b1, {SW{1'b0}}};
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      res_r   <= res_nxt;
      if (state_r == S_IDLE && in_valid) begin
        act_r  <= in_action;
        hdl_r  <= in_handle;
        byte_r <= in_byte_in;
        idx_r  <= in_index;
      end
    end
  end

endmodule

### verif/ghbb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghbb_checker
// Watches both channels of the handle buffer table, keeps its own copy of
// the slot table and byte store, and compares every result transaction
// against the predicted one in order.
// ----------------------------------------------------------------------------
module ghbb_checker
  import ghbb_pkg::*;
#(
  parameter int SLOT_W    = 8,
  parameter int GEN_W     = 16,
  parameter int BUF_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [BYTE_W-1:0]   in_byte_in,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [HANDLE_W-1:0] out_handle_out,
  input  logic [LENGTH_W-1:0] out_length,
  input  logic [BYTE_W-1:0]   out_byte_out,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int SLOTS = 1 << SLOT_W;

  // shadow of the slot table, free list and byte store
  bit [GEN_W-1:0]    slot_gen    [SLOTS];
  bit [LENGTH_W-1:0] slot_len    [SLOTS];
  bit                slot_closed [SLOTS];
  bit [SLOT_W:0]     free_link   [SLOTS];
  bit [BYTE_W-1:0]   byte_mem    [SLOTS * BUF_BYTES];
  bit [SLOT_W:0]     shadow_head = (SLOT_W+1)'(SLOTS);
  bit [SLOT_W:0]     fresh_count = '0;

  result_t expected_q [$];
  result_t got;
  result_t want;
  int      fail_total = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // slot handed out and generation field equal, closed flag ignored
  function automatic bit gen_matches(input logic [HANDLE_W-1:0] h);
    int s;
    s = int'(h[SLOT_W-1:0]);
    if (s >= int'(fresh_count)) return 1'b0;
    return (h >> SLOT_W) == HANDLE_W'(slot_gen[s]);
  endfunction

  function automatic bit handle_live(input logic [HANDLE_W-1:0] h);
    return gen_matches(h) && !slot_closed[int'(h[SLOT_W-1:0])];
  endfunction

  // apply one request to the shadow table and return its response
  function automatic result_t predict_response(input logic [ACTION_W-1:0] act,
                                               input logic [HANDLE_W-1:0] h,
                                               input logic [BYTE_W-1:0]   b,
                                               input logic [INDEX_W-1:0]  idx);
    result_t r;
    int      s;
    r = '0;
    r.status = STAT_OK;
    s = int'(h[SLOT_W-1:0]);
    case (action_t'(act))
      ACT_ALLOC: begin
        if (int'(shadow_head) < SLOTS) begin
          s = int'(shadow_head);
          shadow_head = free_link[s];
          slot_gen[s] = slot_gen[s] + 1'b1;
        end else if (int'(fresh_count) < SLOTS) begin
          s = int'(fresh_count);
          fresh_count = fresh_count + 1'b1;
          slot_gen[s] = '0;
        end else begin
          r.status = STAT_FULL;
          return r;
        end
        slot_len[s]    = '0;
        slot_closed[s] = 1'b0;
        r.handle_out = HANDLE_W'(s) | (HANDLE_W'(slot_gen[s]) << SLOT_W);
      end
      ACT_PUSH: begin
        if (!handle_live(h)) begin
          r.status = STAT_BAD;
        end else if (int'(slot_len[s]) >= BUF_BYTES) begin
          r.status = STAT_FULL;
          r.length = slot_len[s];
        end else begin
          byte_mem[s * BUF_BYTES + int'(slot_len[s])] = b;
          slot_len[s] = slot_len[s] + 1'b1;
          r.length = slot_len[s];
        end
      end
      ACT_LENGTH: begin
        if (!handle_live(h)) r.status = STAT_BAD;
        else                 r.length = slot_len[s];
      end
      ACT_CLOSE: begin
        if (!gen_matches(h)) begin
          r.status = STAT_BAD;
        end else if (!slot_closed[s]) begin
          // free the slot onto the head of the free list
          slot_closed[s] = 1'b1;
          slot_len[s]    = '0;
          free_link[s]   = shadow_head;
          shadow_head    = (SLOT_W+1)'(s);
        end
      end
      ACT_READ: begin
        if (!handle_live(h) || int'(idx) >= int'(slot_len[s])) r.status = STAT_BAD;
        else r.byte_out = byte_mem[s * BUF_BYTES + int'(idx)];
      end
      default: r.status = STAT_BAD;
    endcase
    return r;
  endfunction

  // compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_head = (SLOT_W+1)'(SLOTS);
      fresh_count = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_handle_out, out_length, out_byte_out};
        if (expected_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t unexpected result transaction: ", $realtime,
                     "status %0d handle %06h len %0d byte %02h",
                     got.status, got.handle_out, got.length, got.byte_out);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.handle_out !== want.handle_out ||
              got.length !== want.length || got.byte_out !== want.byte_out) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t result differs: ", $realtime,
                       "expected status %0d handle %06h len %0d byte %02h, ",
                       want.status, want.handle_out, want.length, want.byte_out,
                       "got status %0d handle %06h len %0d byte %02h",
                       got.status, got.handle_out, got.length, got.byte_out);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_response(in_action, in_handle, in_byte_in, in_index));
    end
    mismatches  <= fail_total;
    outstanding <= expected_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the handle buffer table with a directed opening and phases of
// handle-aware random requests under varying idle and stall pressure; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import ghbb_pkg::*;

  localparam int SLOT_W    = 8;
  localparam int GEN_W     = 16;
  localparam int BUF_BYTES = 64;

  // action codes the block does not implement
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action      = '0;
  logic [HANDLE_W-1:0] in_handle      = '0;
  logic [BYTE_W-1:0]   in_byte_in     = '0;
  logic [INDEX_W-1:0]  in_index       = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [LENGTH_W-1:0] out_length;
  logic [BYTE_W-1:0]   out_byte_out;
  int                  mismatches;
  int                  outstanding;

  int                  idle_pct  = 0;
  int                  stall_pct = 0;
  int                  issued    = 0;
  logic [ACTION_W-1:0] sent_actions [$];
  logic [HANDLE_W-1:0] handle_pool  [$];

  always #2 clk = ~clk;

  generational_handle_byte_buffers #(
    .SLOT_WIDTH      (SLOT_W),
    .GENERATION_WIDTH(GEN_W),
    .BUFFER_BYTES    (BUF_BYTES)
  ) u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_handle, .in_byte_in, .in_index,
    .out_valid, .out_stall, .out_status, .out_handle_out, .out_length, .out_byte_out
  );

  ghbb_checker #(
    .SLOT_W   (SLOT_W),
    .GEN_W    (GEN_W),
    .BUF_BYTES(BUF_BYTES)
  ) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_handle, .in_byte_in, .in_index,
    .out_valid, .out_stall, .out_status, .out_handle_out, .out_length, .out_byte_out,
    .mismatches, .outstanding
  );

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // collect granted handles; signals are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall && sent_actions.size() > 0) begin
        if (sent_actions.pop_front() == ACT_ALLOC && out_status == STAT_OK)
          handle_pool.push_back(out_handle_out);
      end
      if (in_valid && !in_stall) sent_actions.push_back(in_action);
    end
  end

  // present one request transaction and wait for it to be taken
  task automatic send(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] h,
                      input logic [BYTE_W-1:0] b, input logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_handle  <= h;
    in_byte_in <= b;
    in_index   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued++;
  endtask

  // mostly recent handles, sometimes any handle seen so far
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int n;
    int k;
    n = handle_pool.size();
    if (n == 0) return HANDLE_W'($urandom);
    if ($urandom_range(0, 3) != 0) k = n - 1 - $urandom_range(0, (n > 8) ? 7 : n - 1);
    else                           k = $urandom_range(0, n - 1);
    return handle_pool[k];
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 1) != 0) return INDEX_W'($urandom_range(0, 15));
    return INDEX_W'($urandom_range(0, 63));
  endfunction

  // random episodes of well-formed request sequences plus some noise
  task automatic run_random(input int n_items);
    int                  first;
    int                  k;
    int                  cnt;
    logic [HANDLE_W-1:0] h;
    first = issued;
    while (issued - first < n_items) begin
      k = $urandom_range(0, 99);
      h = pick_handle();
      if (k < 15) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) send(ACT_ALLOC, HANDLE_W'($urandom), BYTE_W'($urandom), pick_index());
      end else if (k < 35) begin
        // occasionally push past the buffer capacity
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(BUF_BYTES + 1, BUF_BYTES + 6)
                                         : $urandom_range(1, 8);
        repeat (cnt) send(ACT_PUSH, h, BYTE_W'($urandom), pick_index());
      end else if (k < 55) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) send(ACT_READ, h, BYTE_W'($urandom), pick_index());
      end else if (k < 65) begin
        send(ACT_LENGTH, h, BYTE_W'($urandom), pick_index());
      end else if (k < 78) begin
        send(ACT_CLOSE, h, BYTE_W'($urandom), pick_index());
        if ($urandom_range(0, 3) == 0) send(ACT_CLOSE, h, BYTE_W'($urandom), pick_index());
      end else if (k < 85) begin
        // one flipped handle bit
        h = h ^ (HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1));
        send(ACTION_W'($urandom_range(ACT_PUSH, ACT_READ)), h, BYTE_W'($urandom),
             pick_index());
      end else if (k < 93) begin
        send(ACTION_W'($urandom_range(0, 7)), HANDLE_W'($urandom), BYTE_W'($urandom),
             INDEX_W'($urandom));
      end else begin
        send(ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), h,
             BYTE_W'($urandom), INDEX_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening: fresh slot, bytes at the extremes, bad handles,
    // double and stale close, reuse from the free list, unused actions
    send(ACT_ALLOC,  24'h000000, 8'h00, 6'd0);
    send(ACT_LENGTH, 24'h000000, 8'h00, 6'd0);
    send(ACT_PUSH,   24'h000000, 8'h00, 6'd0);
    send(ACT_PUSH,   24'h000000, 8'hFF, 6'd63);
    send(ACT_READ,   24'h000000, 8'h00, 6'd0);
    send(ACT_READ,   24'h000000, 8'h00, 6'd1);
    send(ACT_READ,   24'h000000, 8'h00, 6'd2);
    send(ACT_READ,   24'h000000, 8'h00, 6'd63);
    send(ACT_PUSH,   24'h000005, 8'hA5, 6'd0);
    send(ACT_LENGTH, 24'hFFFF00, 8'h00, 6'd0);
    send(ACT_PUSH,   24'hFFFFFF, 8'hFF, 6'd63);
    send(ACT_CLOSE,  24'h000000, 8'h00, 6'd0);
    send(ACT_CLOSE,  24'h000000, 8'h00, 6'd0);
    send(ACT_PUSH,   24'h000000, 8'h5A, 6'd0);
    send(ACT_LENGTH, 24'h000000, 8'h00, 6'd0);
    send(ACT_READ,   24'h000000, 8'h00, 6'd0);
    send(ACT_ALLOC,  24'h000000, 8'h00, 6'd0);
    send(ACT_CLOSE,  24'h000000, 8'h00, 6'd0);
    send(ACT_LENGTH, 24'h000100, 8'h00, 6'd0);
    send(ACT_READ,   24'h000100, 8'h00, 6'd0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send(ACTION_W'(a), 24'h000100, 8'hFF, 6'd63);
    send(ACT_ALLOC,  24'hFFFFFF, 8'h00, 6'd0);

    // no idling
    run_random(250);
    // sender mostly idle
    idle_pct = 74;
    run_random(250);
    // receiver mostly stalling; fill the table first
    idle_pct  = 0;
    stall_pct = 74;
    repeat ((1 << SLOT_W) + 4) send(ACT_ALLOC, HANDLE_W'($urandom), BYTE_W'($urandom),
                                    INDEX_W'($urandom));
    run_random(250);
    // light pressure on both sides
    idle_pct  = 15;
    stall_pct = 15;
    run_random(250);

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
